// ===== rtl/lru_range_cache_with_job_queue_unit_macros.svh =====
// Assertion macros shared by the range cache RTL.
`ifndef LRU_RANGE_CACHE_WITH_JOB_QUEUE_UNIT_MACROS_SVH
`define LRU_RANGE_CACHE_WITH_JOB_QUEUE_UNIT_MACROS_SVH

// Check that expr holds at every clock edge outside reset.
`define LRC_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lrc invariant check failed");

// Check that cons holds in the same cycle as ante.
`define LRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lrc implication check failed");

// Check that cons holds in the cycle after ante.
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lrc next-cycle check failed");

`endif

// ===== rtl/lrc_pkg.sv =====
// Shared constants, codes and types of the range cache.
package lrc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int RANK_W  = IDX_W;
    localparam int KEY_W   = 32;
    localparam int FUNC_W  = 2;
    localparam int SLOT_W  = 4;

    localparam logic [FUNC_W-1:0] FUNC_LOOKUP   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_TAKE     = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPLETE = 2'd2;

    localparam logic [2:0] UPD_NONE      = 3'd0;
    localparam logic [2:0] UPD_TOUCH     = 3'd1;
    localparam logic [2:0] UPD_INSERT    = 3'd2;
    localparam logic [2:0] UPD_CLR_PEND  = 3'd3;
    localparam logic [2:0] UPD_SET_READY = 3'd4;

    typedef logic [ENTRIES-1:0][RANK_W-1:0] t_rank_vec;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] idx;
    } t_upd;

    typedef struct packed {
        logic eq_start;
        logic lt_start;
        logic eq_end;
        logic lt_end;
    } t_cmp;

endpackage

// ===== rtl/lru_range_cache_with_job_queue_unit.sv =====
// One item at a time: the sequencer walks every stored key through the single read port
// of the key memory and the shared compare unit before it takes the next item.
// The input is not ready during the walk; a finished result waits in the output register.
// Reset (synchronous, active low) clears valid, pending and ready marks, ranks and the
// sequencer; the key memory is not cleared.
`include "lru_range_cache_with_job_queue_unit_macros.svh"

module lru_range_cache_with_job_queue_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [lrc_pkg::FUNC_W-1:0]         i_func,
    input  logic signed [lrc_pkg::KEY_W-1:0]   i_range_start,
    input  logic signed [lrc_pkg::KEY_W-1:0]   i_range_end,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_found,
    output logic                               o_ready_res,
    output logic [lrc_pkg::SLOT_W-1:0]         o_slot,
    output logic                               o_job_valid,
    output logic signed [lrc_pkg::KEY_W-1:0]   o_job_start,
    output logic signed [lrc_pkg::KEY_W-1:0]   o_job_end
);
    import lrc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WALK = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic [1:0]              r_state, n_state;
    logic [FUNC_W-1:0]       r_func;
    logic signed [KEY_W-1:0] r_key_s, r_key_e;
    logic [CNT_W-1:0]        r_cnt;
    logic                    r_cmp_vld;
    logic [IDX_W-1:0]        r_cmp_idx;

    logic signed [KEY_W-1:0] m_start [ENTRIES];
    logic signed [KEY_W-1:0] m_end   [ENTRIES];
    logic signed [KEY_W-1:0] r_rd_s, r_rd_e;

    logic                    r_hit, r_free, r_best_v;
    logic [IDX_W-1:0]        r_hit_idx, r_free_idx, r_lru_idx, r_best_idx;
    logic [RANK_W-1:0]       r_worst;
    logic signed [KEY_W-1:0] r_best_s, r_best_e;

    logic                    r_out_valid, r_found, r_ready_res, r_job_valid;
    logic [SLOT_W-1:0]       r_slot;
    logic signed [KEY_W-1:0] r_job_s, r_job_e;

    logic                    n_found, n_ready_res, n_job_valid;
    logic [SLOT_W-1:0]       n_slot;
    logic signed [KEY_W-1:0] n_job_s, n_job_e;

    logic                    in_xfer, fin_go, mem_we, take_op, better;
    logic [IDX_W-1:0]        victim;
    logic signed [KEY_W-1:0] cmp_b_s, cmp_b_e;
    t_cmp                    cmp;
    t_upd                    upd;
    logic [ENTRIES-1:0]      st_valid, st_pending, st_ready;
    t_rank_vec               st_rank;

    assign in_xfer    = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == ST_IDLE);
    assign fin_go     = (r_state == ST_FIN) && (!r_out_valid || i_out_ready);
    assign take_op    = (r_func == FUNC_TAKE);
    assign victim     = r_free ? r_free_idx : r_lru_idx;
    assign cmp_b_s    = take_op ? r_best_s : r_key_s;
    assign cmp_b_e    = take_op ? r_best_e : r_key_e;
    assign better     = !r_best_v || cmp.lt_start || (cmp.eq_start && cmp.lt_end);

    lrc_cmp u_cmp (
        .i_a_start (r_rd_s),
        .i_a_end   (r_rd_e),
        .i_b_start (cmp_b_s),
        .i_b_end   (cmp_b_e),
        .o_cmp     (cmp)
    );

    lrc_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_upd     (upd),
        .o_valid   (st_valid),
        .o_pending (st_pending),
        .o_ready   (st_ready),
        .o_rank    (st_rank)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_cnt == CNT_W'(ENTRIES)) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (fin_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        upd.op      = UPD_NONE;
        upd.idx     = '0;
        mem_we      = 1'b0;
        n_found     = 1'b0;
        n_ready_res = 1'b0;
        n_slot      = '0;
        n_job_valid = 1'b0;
        n_job_s     = '0;
        n_job_e     = '0;
        case (r_func)
            FUNC_LOOKUP: begin
                if (r_hit) begin
                    upd.op      = UPD_TOUCH;
                    upd.idx     = r_hit_idx;
                    n_found     = 1'b1;
                    n_ready_res = st_ready[r_hit_idx];
                    n_slot      = SLOT_W'(r_hit_idx);
                end else begin
                    upd.op  = UPD_INSERT;
                    upd.idx = victim;
                    mem_we  = 1'b1;
                    n_slot  = SLOT_W'(victim);
                end
            end
            FUNC_TAKE: begin
                if (r_best_v) begin
                    upd.op      = UPD_CLR_PEND;
                    upd.idx     = r_best_idx;
                    n_job_valid = 1'b1;
                    n_job_s     = r_best_s;
                    n_job_e     = r_best_e;
                end
            end
            FUNC_COMPLETE: begin
                if (r_hit) begin
                    upd.op  = UPD_SET_READY;
                    upd.idx = r_hit_idx;
                    n_found = 1'b1;
                    n_slot  = SLOT_W'(r_hit_idx);
                end
            end
            default: begin
            end
        endcase
        if (!fin_go) begin
            upd.op = UPD_NONE;
            mem_we = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_start[victim] <= r_key_s;
            m_end[victim]   <= r_key_e;
        end
        r_rd_s <= m_start[r_cnt[IDX_W-1:0]];
        r_rd_e <= m_end[r_cnt[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) begin
                r_cnt     <= '0;
                r_cmp_vld <= 1'b0;
            end else if (r_state == ST_WALK) begin
                r_cmp_vld <= (r_cnt < CNT_W'(ENTRIES));
                if (r_cnt != CNT_W'(ENTRIES)) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end else begin
                r_cmp_vld <= 1'b0;
            end
            if (fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx <= r_cnt[IDX_W-1:0];
        if (in_xfer) begin
            r_func     <= i_func;
            r_key_s    <= i_range_start;
            r_key_e    <= i_range_end;
            r_hit      <= 1'b0;
            r_hit_idx  <= '0;
            r_free     <= 1'b0;
            r_free_idx <= '0;
            r_worst    <= '0;
            r_lru_idx  <= '0;
            r_best_v   <= 1'b0;
            r_best_idx <= '0;
            r_best_s   <= '0;
            r_best_e   <= '0;
        end else if (r_cmp_vld) begin
            if (st_valid[r_cmp_idx] && cmp.eq_start && cmp.eq_end && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
            end
            if (!st_valid[r_cmp_idx] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
            if (st_rank[r_cmp_idx] >= r_worst) begin
                r_worst   <= st_rank[r_cmp_idx];
                r_lru_idx <= r_cmp_idx;
            end
            if (st_valid[r_cmp_idx] && st_pending[r_cmp_idx] && better) begin
                r_best_v   <= 1'b1;
                r_best_idx <= r_cmp_idx;
                r_best_s   <= r_rd_s;
                r_best_e   <= r_rd_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_found     <= n_found;
            r_ready_res <= n_ready_res;
            r_slot      <= n_slot;
            r_job_valid <= n_job_valid;
            r_job_s     <= n_job_s;
            r_job_e     <= n_job_e;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_ready_res = r_ready_res;
    assign o_slot      = r_slot;
    assign o_job_valid = r_job_valid;
    assign o_job_start = r_job_s;
    assign o_job_end   = r_job_e;

    `LRC_ASSERT_NEXT(a_busy_after_xfer, i_clk, i_rst_n, in_xfer, !o_in_ready)
    `LRC_ASSERT_IMP(a_out_from_fin, i_clk, i_rst_n, $rose(o_out_valid), $past(r_state) == ST_FIN)
    `LRC_ASSERT_IMP(a_no_job_zero, i_clk, i_rst_n, o_out_valid && !o_job_valid, (o_job_start == '0) && (o_job_end == '0))

endmodule

// ===== rtl/lrc_cmp.sv =====
// Shared key compare unit: equality and signed order of two range keys.
module lrc_cmp (
    input  logic signed [lrc_pkg::KEY_W-1:0] i_a_start,
    input  logic signed [lrc_pkg::KEY_W-1:0] i_a_end,
    input  logic signed [lrc_pkg::KEY_W-1:0] i_b_start,
    input  logic signed [lrc_pkg::KEY_W-1:0] i_b_end,
    output lrc_pkg::t_cmp                    o_cmp
);
    import lrc_pkg::*;

    always_comb begin
        o_cmp.eq_start = (i_a_start == i_b_start);
        o_cmp.lt_start = (i_a_start < i_b_start);
        o_cmp.eq_end   = (i_a_end == i_b_end);
        o_cmp.lt_end   = (i_a_end < i_b_end);
    end

endmodule

// ===== rtl/lrc_state.sv =====
// Per-entry marks and recency ranks with their update operations.
`include "lru_range_cache_with_job_queue_unit_macros.svh"

module lrc_state (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrc_pkg::t_upd               i_upd,
    output logic [lrc_pkg::ENTRIES-1:0] o_valid,
    output logic [lrc_pkg::ENTRIES-1:0] o_pending,
    output logic [lrc_pkg::ENTRIES-1:0] o_ready,
    output lrc_pkg::t_rank_vec          o_rank
);
    import lrc_pkg::*;

    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [ENTRIES-1:0] r_pending, n_pending;
    logic [ENTRIES-1:0] r_ready, n_ready;
    t_rank_vec          r_rank, n_rank;
    logic [RANK_W-1:0]  lim;

    always_comb begin
        n_valid   = r_valid;
        n_pending = r_pending;
        n_ready   = r_ready;
        n_rank    = r_rank;
        lim       = r_rank[i_upd.idx];
        case (i_upd.op)
            UPD_TOUCH: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (IDX_W'(i) != i_upd.idx) && (r_rank[i] < lim)) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
                n_rank[i_upd.idx] = '0;
            end
            UPD_INSERT: begin
                for (int i = 0; i < ENTRIES; i++) begin
                    if (r_valid[i] && (IDX_W'(i) != i_upd.idx)) begin
                        n_rank[i] = r_rank[i] + RANK_W'(1);
                    end
                end
                n_rank[i_upd.idx]    = '0;
                n_valid[i_upd.idx]   = 1'b1;
                n_pending[i_upd.idx] = 1'b1;
                n_ready[i_upd.idx]   = 1'b0;
            end
            UPD_CLR_PEND: begin
                n_pending[i_upd.idx] = 1'b0;
            end
            UPD_SET_READY: begin
                n_ready[i_upd.idx] = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_pending <= '0;
            r_ready   <= '0;
            r_rank    <= '0;
        end else begin
            r_valid   <= n_valid;
            r_pending <= n_pending;
            r_ready   <= n_ready;
            r_rank    <= n_rank;
        end
    end

    assign o_valid   = r_valid;
    assign o_pending = r_pending;
    assign o_ready   = r_ready;
    assign o_rank    = r_rank;

    `LRC_ASSERT_ALWAYS(a_marks_need_valid, i_clk, i_rst_n, ((r_pending | r_ready) & ~r_valid) == '0)

endmodule

// ===== tb/sv/lru_range_cache_checker.sv =====
// Checker for the range cache: tracks the tag store, predicts each result and compares it.
module lru_range_cache_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic [lrc_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [lrc_pkg::KEY_W-1:0]    i_range_start,
    input  logic signed [lrc_pkg::KEY_W-1:0]    i_range_end,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic                                i_found,
    input  logic                                i_ready_res,
    input  logic [lrc_pkg::SLOT_W-1:0]          i_slot,
    input  logic                                i_job_valid,
    input  logic signed [lrc_pkg::KEY_W-1:0]    i_job_start,
    input  logic signed [lrc_pkg::KEY_W-1:0]    i_job_end,
    output int                                  o_fail_count,
    output int                                  o_outstanding,
    output int                                  o_compared
);
    import lrc_pkg::*;

    typedef struct {
        logic                    found;
        logic                    ready_res;
        logic [SLOT_W-1:0]       slot;
        logic                    job_valid;
        logic signed [KEY_W-1:0] job_start;
        logic signed [KEY_W-1:0] job_end;
    } t_cache_result;

    logic signed [KEY_W-1:0] tag_start [ENTRIES];
    logic signed [KEY_W-1:0] tag_end   [ENTRIES];
    logic                    in_use    [ENTRIES];
    logic                    pending   [ENTRIES];
    logic                    done      [ENTRIES];
    int unsigned             age       [ENTRIES];

    t_cache_result awaited [$];
    int errors      = 0;
    int compared    = 0;
    int outstanding = 0;

    assign o_fail_count  = errors;
    assign o_compared    = compared;
    assign o_outstanding = outstanding;

    function automatic int find_tag(logic signed [KEY_W-1:0] s, logic signed [KEY_W-1:0] e);
        for (int i = 0; i < ENTRIES; i++) begin
            if (in_use[i] && tag_start[i] == s && tag_end[i] == e) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Make idx most recent; entries more recent than limit age by one.
    function automatic void promote(int idx, int unsigned limit);
        for (int i = 0; i < ENTRIES; i++) begin
            if (in_use[i] && i != idx && age[i] < limit) begin
                age[i]++;
            end
        end
        age[idx] = 0;
    endfunction

    function automatic t_cache_result apply_request(logic [FUNC_W-1:0] func,
                                                    logic signed [KEY_W-1:0] s,
                                                    logic signed [KEY_W-1:0] e);
        t_cache_result r;
        int            idx;
        int            best;
        int unsigned   oldest;
        r = '{default: 0};
        case (func)
            FUNC_LOOKUP: begin
                idx = find_tag(s, e);
                if (idx >= 0) begin
                    promote(idx, age[idx]);
                    r.found     = 1'b1;
                    r.ready_res = done[idx];
                end else begin
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (!in_use[i] && idx < 0) begin
                            idx = i;
                        end
                    end
                    if (idx < 0) begin
                        oldest = 0;
                        idx    = 0;
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (age[i] >= oldest) begin
                                oldest = age[i];
                                idx    = i;
                            end
                        end
                        in_use[idx] = 1'b0;
                    end
                    promote(idx, 32'hFFFF_FFFF);
                    in_use[idx]    = 1'b1;
                    tag_start[idx] = s;
                    tag_end[idx]   = e;
                    pending[idx]   = 1'b1;
                    done[idx]      = 1'b0;
                end
                r.slot = SLOT_W'(idx);
            end
            FUNC_TAKE: begin
                best = -1;
                for (int i = 0; i < ENTRIES; i++) begin
                    if (in_use[i] && pending[i]) begin
                        if (best < 0 || tag_start[i] < tag_start[best] ||
                            (tag_start[i] == tag_start[best] && tag_end[i] < tag_end[best])) begin
                            best = i;
                        end
                    end
                end
                if (best >= 0) begin
                    pending[best] = 1'b0;
                    r.job_valid   = 1'b1;
                    r.job_start   = tag_start[best];
                    r.job_end     = tag_end[best];
                end
            end
            FUNC_COMPLETE: begin
                idx = find_tag(s, e);
                if (idx >= 0) begin
                    done[idx] = 1'b1;
                    r.found   = 1'b1;
                    r.slot    = SLOT_W'(idx);
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    task automatic compare_field(string name, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_cache_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < ENTRIES; i++) begin
                in_use[i]  = 1'b0;
                pending[i] = 1'b0;
                done[i]    = 1'b0;
                age[i]     = 0;
            end
            awaited.delete();
            outstanding <= 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    $error("result transfer with no request outstanding");
                    errors++;
                end else begin
                    want = awaited.pop_front();
                    compare_field("found", want.found, i_found);
                    compare_field("ready_res", want.ready_res, i_ready_res);
                    compare_field("slot", want.slot, i_slot);
                    compare_field("job_valid", want.job_valid, i_job_valid);
                    compare_field("job_start", want.job_start, i_job_start);
                    compare_field("job_end", want.job_end, i_job_end);
                    compared++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                awaited.insert(awaited.size(), apply_request(i_func, i_range_start, i_range_end));
            end
            outstanding <= awaited.size();
        end
    end

endmodule

// ===== tb/sv/tb_lru_range_cache_with_job_queue_unit.sv =====
// Testbench top for the range cache: drives lookup, job and completion traffic and reports.
module tb_lru_range_cache_with_job_queue_unit;
    import lrc_pkg::*;

    localparam logic [FUNC_W-1:0]       FUNC_UNUSED = 2'd3;
    localparam logic signed [KEY_W-1:0] KEY_MIN     = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX     = 32'sh7FFF_FFFF;
    localparam int POOL_SIZE   = 24;
    localparam int PHASE_ITEMS = 100;
    localparam int PHASES      = 13;
    localparam int TAIL_CYCLES = 40;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic [FUNC_W-1:0]       i_func;
    logic signed [KEY_W-1:0] i_range_start;
    logic signed [KEY_W-1:0] i_range_end;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic                    o_found;
    logic                    o_ready_res;
    logic [SLOT_W-1:0]       o_slot;
    logic                    o_job_valid;
    logic signed [KEY_W-1:0] o_job_start;
    logic signed [KEY_W-1:0] o_job_end;

    int fail_count;
    int outstanding;
    int compared;

    logic signed [KEY_W-1:0] pool_start [POOL_SIZE];
    logic signed [KEY_W-1:0] pool_end   [POOL_SIZE];
    int gap_pct   = 0;
    int stall_pct = 0;
    int n_lookup  = 0;
    int n_take    = 0;
    int n_complete = 0;
    int n_other   = 0;

    lru_range_cache_with_job_queue_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_found       (o_found),
        .o_ready_res   (o_ready_res),
        .o_slot        (o_slot),
        .o_job_valid   (o_job_valid),
        .o_job_start   (o_job_start),
        .o_job_end     (o_job_end)
    );

    lru_range_cache_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_func        (i_func),
        .i_range_start (i_range_start),
        .i_range_end   (i_range_end),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_found       (o_found),
        .i_ready_res   (o_ready_res),
        .i_slot        (o_slot),
        .i_job_valid   (o_job_valid),
        .i_job_start   (o_job_start),
        .i_job_end     (o_job_end),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_compared    (compared)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 8);
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    function automatic logic signed [KEY_W-1:0] pick_key_value();
        case ($urandom_range(0, 7))
            0:       return KEY_MIN;
            1:       return KEY_MAX;
            2:       return -32'sd1;
            3:       return 32'sd0;
            default: return $urandom;
        endcase
    endfunction

    // Share starts between keys so that take-job ordering falls back to the end.
    task automatic refresh_pool(int count);
        int k;
        repeat (count) begin
            k = $urandom_range(0, POOL_SIZE - 1);
            pool_start[k] = $urandom_range(0, 1) ? pool_start[$urandom_range(0, POOL_SIZE - 1)]
                                                 : pick_key_value();
            pool_end[k]   = pick_key_value();
        end
    endtask

    task automatic send_request(logic [FUNC_W-1:0] f, logic signed [KEY_W-1:0] s,
                                logic signed [KEY_W-1:0] e);
        i_in_valid    <= 1'b1;
        i_func        <= f;
        i_range_start <= s;
        i_range_end   <= e;
        do @(posedge i_clk); while (!o_in_ready);
        if (f == FUNC_LOOKUP) begin
            n_lookup++;
        end else if (f == FUNC_TAKE) begin
            n_take++;
        end else if (f == FUNC_COMPLETE) begin
            n_complete++;
        end else begin
            n_other++;
        end
    endtask

    task automatic idle_sender();
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    initial begin
        int span;
        int k;
        int roll;
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_func        <= FUNC_LOOKUP;
        i_range_start <= '0;
        i_range_end   <= '0;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_start[i] = pick_key_value();
            pool_end[i]   = pick_key_value();
        end
        refresh_pool(POOL_SIZE);
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        stall_pct = 20;
        send_request(FUNC_TAKE, '0, '0);
        send_request(FUNC_COMPLETE, 32'sd5, 32'sd5);
        send_request(FUNC_UNUSED, '1, '1);
        send_request(FUNC_LOOKUP, KEY_MIN, KEY_MAX);
        send_request(FUNC_LOOKUP, KEY_MAX, KEY_MIN);
        send_request(FUNC_LOOKUP, -32'sd1, 32'sd0);
        send_request(FUNC_LOOKUP, 32'sd0, -32'sd1);
        send_request(FUNC_LOOKUP, -32'sd1, -32'sd1);
        send_request(FUNC_LOOKUP, KEY_MIN, KEY_MAX);
        send_request(FUNC_COMPLETE, KEY_MIN, KEY_MAX);
        send_request(FUNC_LOOKUP, KEY_MIN, KEY_MAX);
        repeat (6) send_request(FUNC_TAKE, '1, '1);
        send_request(FUNC_COMPLETE, -32'sd1, -32'sd1);
        send_request(FUNC_LOOKUP, -32'sd1, -32'sd1);
        send_request(FUNC_COMPLETE, KEY_MAX, KEY_MAX);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase == PHASES - 1) begin
                gap_pct   = 0;
                stall_pct = 0;
            end else begin
                gap_pct   = $urandom_range(0, 2) * 20;
                stall_pct = $urandom_range(0, 2) * 20;
            end
            span = $urandom_range(3, POOL_SIZE - 1);
            refresh_pool(4);
            for (int item = 0; item < PHASE_ITEMS; item++) begin
                k    = $urandom_range(0, span);
                roll = $urandom_range(0, 99);
                if (roll < 42) begin
                    send_request(FUNC_LOOKUP, pool_start[k], pool_end[k]);
                end else if (roll < 47) begin
                    send_request(FUNC_LOOKUP, $urandom, $urandom);
                end else if (roll < 69) begin
                    send_request(FUNC_TAKE, $urandom, $urandom);
                end else if (roll < 91) begin
                    send_request(FUNC_COMPLETE, pool_start[k], pool_end[k]);
                end else if (roll < 96) begin
                    send_request(FUNC_COMPLETE, $urandom, $urandom);
                end else begin
                    send_request(FUNC_UNUSED, $urandom, $urandom);
                end
                if (item == PHASE_ITEMS - 1 && phase < PHASES - 1) begin
                    drain();
                end else begin
                    idle_sender();
                end
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Covered %0d lookups, %0d job takes, %0d completions and %0d unused-code items;",
                 n_lookup, n_take, n_complete, n_other);
        $display("%0d results compared with random idling on both channels.", compared);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
